// ===== rtl/rdi_pkg.sv =====
// ----------------------------------------------------------------------------
// rdi_pkg
// Shared types and constants for the ray/disk intersection pipeline:
// register map, field widths and the side data that rides with each item
// through the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rdi_pkg;

  // Field widths
  localparam int COORD_W  = 32;  // Q16.16 coordinates and directions
  localparam int DIFF_W   = 33;  // centre minus origin
  localparam int NORM_W   = 18;  // normal components
  localparam int RAD_W    = 31;  // radius and distance
  localparam int MAG_W    = 53;  // magnitude of the dot products
  localparam int DIV_BITS = 31;  // quotient bits: 15 integer, 16 fraction

  // Saturated distance
  localparam logic [RAD_W-1:0] T_SAT = {RAD_W{1'b1}};

  // Configuration register map, word index
  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_DISK_RADIUS = 3'd3,
    REG_NORMAL_X    = 3'd4,
    REG_NORMAL_Y    = 3'd5,
    REG_NORMAL_Z    = 3'd6
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  // Side data carried alongside the division
  typedef struct {
    logic   miss;      // parallel ray or t not positive
    logic   sat;       // quotient reaches 2^15
    coord_t d    [3];  // ray direction
    diff_t  diff [3];  // centre minus origin
  } rdi_side_t;

endpackage

`default_nettype wire

// ===== rtl/rdi_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rdi_div_pipe
// Fully pipelined restoring divider: one quotient bit per stage, computing
// floor(un * 2^16 / ud) for quotients below 2^31. Side data travels along.
// ----------------------------------------------------------------------------
`default_nettype none

module rdi_div_pipe
  import rdi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic [MAG_W-1:0]    un,
  input  wire logic [MAG_W-1:0]    ud,
  input  var  rdi_side_t           in_side,
  output logic                     out_vld,
  output logic [DIV_BITS-1:0]      quotient,
  output rdi_side_t                out_side
);

  typedef struct {
    logic [MAG_W-1:0]    rem;   // partial remainder
    logic [MAG_W-1:0]    dvs;   // divisor
    logic [DIV_BITS-1:0] low;   // dividend bits still to shift in
    logic [DIV_BITS-1:0] quo;   // quotient bits so far
    rdi_side_t           side;
  } div_stage_t;

  div_stage_t st  [DIV_BITS];
  logic       vld [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    div_stage_t     src;
    logic           src_vld;
    logic [MAG_W:0] rem_sh;
    logic [MAG_W:0] rem_sub;
    logic           take;

    // Select the previous stage, or the input item for the first stage
    if (k == 0) begin : g_first
      always_comb begin
        src.rem  = {15'd0, un[MAG_W-1:15]};
        src.dvs  = ud;
        src.low  = {un[14:0], 16'd0};
        src.quo  = '0;
        src.side = in_side;
      end
      assign src_vld = in_vld;
    end else begin : g_next
      assign src     = st[k-1];
      assign src_vld = vld[k-1];
    end

    // Shift in one dividend bit and try the subtraction
    assign rem_sh  = {src.rem, src.low[DIV_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, src.dvs};
    assign take    = (rem_sh >= {1'b0, src.dvs});

    always_ff @(posedge clk) begin
      if (en) begin
        st[k].rem  <= take ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
        st[k].dvs  <= src.dvs;
        st[k].low  <= {src.low[DIV_BITS-2:0], 1'b0};
        st[k].quo  <= {src.quo[DIV_BITS-2:0], take};
        st[k].side <= src.side;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= src_vld;
      end
    end
  end

  assign out_vld  = vld[DIV_BITS-1];
  assign quotient = st[DIV_BITS-1].quo;
  assign out_side = st[DIV_BITS-1].side;

endmodule

`default_nettype wire

// ===== rtl/ray_disk_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// ray_disk_intersect_unit
// Ray against disk intersection test in signed Q16.16, one ray per item.
// ----------------------------------------------------------------------------
// The unit accepts one ray per clock while in_stall is low and returns one
// result per ray, in order. The pipeline holds the divider for t, which
// resolves one quotient bit per pipeline stage (31 stages), plus five stages
// for the dot products, six for the hit point and radius test, and the
// output register. A two-entry output buffer (output register plus skid
// register) lets the pipeline keep taking rays while a result waits;
// in_stall rises only once both entries are full. Disk registers may be
// written only while no ray is in flight.
`default_nettype none

module ray_disk_intersect_unit
  import rdi_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [4:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // ray input
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [COORD_W-1:0] origin_x,
  input  wire logic signed [COORD_W-1:0] origin_y,
  input  wire logic signed [COORD_W-1:0] origin_z,
  input  wire logic signed [COORD_W-1:0] dir_x,
  input  wire logic signed [COORD_W-1:0] dir_y,
  input  wire logic signed [COORD_W-1:0] dir_z,
  // result output
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          hit,
  output logic [RAD_W-1:0]              distance
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  coord_t                    center [3];
  logic [RAD_W-1:0]          radius;
  logic signed [NORM_W-1:0]  normal [3];
  cfg_reg_t                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[4:2]);

  // Write a register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
      radius    <= RAD_W'(65536);
      normal[0] <= '0;
      normal[1] <= '0;
      normal[2] <= NORM_W'(65536);
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        REG_CENTER_X:    center[0] <= pwdata;
        REG_CENTER_Y:    center[1] <= pwdata;
        REG_CENTER_Z:    center[2] <= pwdata;
        REG_DISK_RADIUS: radius    <= pwdata[RAD_W-1:0];
        REG_NORMAL_X:    normal[0] <= pwdata[NORM_W-1:0];
        REG_NORMAL_Y:    normal[1] <= pwdata[NORM_W-1:0];
        REG_NORMAL_Z:    normal[2] <= pwdata[NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_CENTER_X:    prdata = center[0];
      REG_CENTER_Y:    prdata = center[1];
      REG_CENTER_Z:    prdata = center[2];
      REG_DISK_RADIUS: prdata = {1'b0, radius};
      REG_NORMAL_X:    prdata = 32'(normal[0]);
      REG_NORMAL_Y:    prdata = 32'(normal[1]);
      REG_NORMAL_Z:    prdata = 32'(normal[2]);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: all stages move together while the skid entry is free
  // --------------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Stage valid bits
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic m1_valid, m2_valid, m3_valid, m4_valid, m5_valid, m6_valid;
  logic div_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
      m5_valid <= 1'b0;
      m6_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      m1_valid <= div_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
      m5_valid <= m4_valid;
      m6_valid <= m5_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture direction, form centre minus origin
  // --------------------------------------------------------------------------
  coord_t s1_d    [3];
  diff_t  s1_diff [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d[0]    <= dir_x;
      s1_d[1]    <= dir_y;
      s1_d[2]    <= dir_z;
      s1_diff[0] <= DIFF_W'(center[0]) - DIFF_W'(origin_x);
      s1_diff[1] <= DIFF_W'(center[1]) - DIFF_W'(origin_y);
      s1_diff[2] <= DIFF_W'(center[2]) - DIFF_W'(origin_z);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: products for both dot products
  // --------------------------------------------------------------------------
  logic signed [49:0] s2_pd [3];   // normal * direction
  logic signed [50:0] s2_pn [3];   // (centre - origin) * normal
  coord_t             s2_d    [3];
  diff_t              s2_diff [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_pd[i]   <= 50'(s1_d[i]) * 50'(normal[i]);
        s2_pn[i]   <= 51'(s1_diff[i]) * 51'(normal[i]);
        s2_d[i]    <= s1_d[i];
        s2_diff[i] <= s1_diff[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum the products
  // --------------------------------------------------------------------------
  logic signed [51:0] s3_den;
  logic signed [52:0] s3_num;
  coord_t             s3_d    [3];
  diff_t              s3_diff [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_den <= 52'(s2_pd[0]) + 52'(s2_pd[1]) + 52'(s2_pd[2]);
      s3_num <= 53'(s2_pn[0]) + 53'(s2_pn[1]) + 53'(s2_pn[2]);
      for (int i = 0; i < 3; i++) begin
        s3_d[i]    <= s2_d[i];
        s3_diff[i] <= s2_diff[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sign test on t, magnitudes for the divider
  // --------------------------------------------------------------------------
  logic signed [MAG_W-1:0] den_ext;
  logic                    s4_miss;
  logic [MAG_W-1:0]        s4_un;
  logic [MAG_W-1:0]        s4_ud;
  coord_t                  s4_d    [3];
  diff_t                   s4_diff [3];

  assign den_ext = MAG_W'(s3_den);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_miss <= (s3_den == '0) || (s3_num == '0) || (s3_num[MAG_W-1] != s3_den[51]);
      s4_un   <= s3_num[MAG_W-1] ? MAG_W'(-s3_num) : MAG_W'(s3_num);
      s4_ud   <= s3_den[51] ? MAG_W'(-den_ext) : MAG_W'(den_ext);
      for (int i = 0; i < 3; i++) begin
        s4_d[i]    <= s3_d[i];
        s4_diff[i] <= s3_diff[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: detect a quotient of 2^15 or more
  // --------------------------------------------------------------------------
  rdi_side_t        s5_side;
  logic [MAG_W-1:0] s5_un;
  logic [MAG_W-1:0] s5_ud;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side.miss <= s4_miss;
      s5_side.sat  <= ({15'd0, s4_un[MAG_W-1:15]} >= s4_ud);
      for (int i = 0; i < 3; i++) begin
        s5_side.d[i]    <= s4_d[i];
        s5_side.diff[i] <= s4_diff[i];
      end
      s5_un <= s4_un;
      s5_ud <= s4_ud;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: t in Q16.16
  // --------------------------------------------------------------------------
  logic [DIV_BITS-1:0] div_q;
  rdi_side_t           div_side;

  rdi_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s5_valid),
    .un       (s5_un),
    .ud       (s5_ud),
    .in_side  (s5_side),
    .out_vld  (div_valid),
    .quotient (div_q),
    .out_side (div_side)
  );

  // --------------------------------------------------------------------------
  // M1: saturate t, multiply direction by t
  // --------------------------------------------------------------------------
  logic [RAD_W-1:0]   tq;
  coord_t             tq_s;
  logic               m1_miss;
  logic [RAD_W-1:0]   m1_tq;
  logic signed [63:0] m1_prod [3];
  diff_t              m1_diff [3];

  assign tq   = div_side.sat ? T_SAT : div_q;
  assign tq_s = signed'({1'b0, tq});

  always_ff @(posedge clk) begin
    if (en) begin
      m1_miss <= div_side.miss;
      m1_tq   <= tq;
      for (int i = 0; i < 3; i++) begin
        m1_prod[i] <= 64'(div_side.d[i]) * 64'(tq_s);
        m1_diff[i] <= div_side.diff[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // M2: hit point relative to centre, each term floored to Q16.16
  // --------------------------------------------------------------------------
  logic               m2_miss;
  logic [RAD_W-1:0]   m2_tq;
  logic signed [47:0] m2_v [3];

  always_ff @(posedge clk) begin
    if (en) begin
      m2_miss <= m1_miss;
      m2_tq   <= m1_tq;
      for (int i = 0; i < 3; i++) begin
        m2_v[i] <= 48'(m1_prod[i] >>> 16) - 48'(m1_diff[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // M3: component magnitudes
  // --------------------------------------------------------------------------
  logic             m3_miss;
  logic [RAD_W-1:0] m3_tq;
  logic [47:0]      m3_mv [3];

  always_ff @(posedge clk) begin
    if (en) begin
      m3_miss <= m2_miss;
      m3_tq   <= m2_tq;
      for (int i = 0; i < 3; i++) begin
        m3_mv[i] <= m2_v[i][47] ? 48'(-m2_v[i]) : 48'(m2_v[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // M4: reject far components, square the rest, square the radius
  // --------------------------------------------------------------------------
  logic             m4_miss;
  logic             m4_far;
  logic [RAD_W-1:0] m4_tq;
  logic [61:0]      m4_sq [3];
  logic [61:0]      m4_rr;

  always_ff @(posedge clk) begin
    if (en) begin
      m4_miss <= m3_miss;
      m4_far  <= (m3_mv[0] > {17'd0, radius}) || (m3_mv[1] > {17'd0, radius}) ||
                 (m3_mv[2] > {17'd0, radius});
      m4_tq   <= m3_tq;
      for (int i = 0; i < 3; i++) begin
        m4_sq[i] <= 62'(m3_mv[i][RAD_W-1:0]) * 62'(m3_mv[i][RAD_W-1:0]);
      end
      m4_rr <= 62'(radius) * 62'(radius);
    end
  end

  // --------------------------------------------------------------------------
  // M5: squared distance from the centre
  // --------------------------------------------------------------------------
  logic             m5_miss;
  logic             m5_far;
  logic [RAD_W-1:0] m5_tq;
  logic [63:0]      m5_sum;
  logic [61:0]      m5_rr;

  always_ff @(posedge clk) begin
    if (en) begin
      m5_miss <= m4_miss;
      m5_far  <= m4_far;
      m5_tq   <= m4_tq;
      m5_sum  <= 64'(m4_sq[0]) + 64'(m4_sq[1]) + 64'(m4_sq[2]);
      m5_rr   <= m4_rr;
    end
  end

  // --------------------------------------------------------------------------
  // M6: final decision
  // --------------------------------------------------------------------------
  logic             m6_hit;
  logic [RAD_W-1:0] m6_dist;
  logic             res_hit;

  assign res_hit = !m5_miss && !m5_far && (m5_sum <= {2'b00, m5_rr});

  always_ff @(posedge clk) begin
    if (en) begin
      m6_hit  <= res_hit;
      m6_dist <= res_hit ? m5_tq : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid entry
  // --------------------------------------------------------------------------
  logic             out_load;
  logic             skid_hit;
  logic [RAD_W-1:0] skid_dist;

  assign out_load = !out_valid || !out_stall;

  // Track occupancy of the output register and the skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= skid_valid || m6_valid;
      skid_valid <= 1'b0;
    end else if (en && m6_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Move result payload into the output register or park it in the skid entry
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        hit      <= skid_hit;
        distance <= skid_dist;
      end else begin
        hit      <= m6_hit;
        distance <= m6_dist;
      end
    end else if (en && m6_valid) begin
      skid_hit  <= m6_hit;
      skid_dist <= m6_dist;
    end
  end

endmodule

`default_nettype wire

// ===== test/disk_hit_checker.sv =====
// ----------------------------------------------------------------------------
// disk_hit_checker
// Watches the register port and both item channels of the ray/disk unit,
// keeps its own copy of the disk registers, predicts hit and distance for
// every ray taken in, and compares each result leaving the unit against the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module disk_hit_checker
  import rdi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  coord_t           origin_x,
  input  coord_t           origin_y,
  input  coord_t           origin_z,
  input  coord_t           dir_x,
  input  coord_t           dir_y,
  input  coord_t           dir_z,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             hit,
  input  logic [RAD_W-1:0] distance,
  output int               error_count,
  output int               results_pending,
  output int               rays_checked,
  output int               hit_count,
  output int               sat_hit_count,
  output int               zero_hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;
  // a whole-number quotient at or above this saturates the distance
  localparam longint unsigned SAT_QUOTIENT = 64'd1 << 15;

  typedef struct packed {
    logic             hit;
    logic [RAD_W-1:0] distance;
  } disk_result_t;

  coord_t                   disk_center [3];
  logic [RAD_W-1:0]         disk_radius;
  logic signed [NORM_W-1:0] disk_normal [3];
  disk_result_t             predicted_q [$];
  int                       mismatches = 0;
  int                       results_seen = 0;
  int                       rays_seen = 0;
  int                       hits_seen = 0;
  int                       sat_seen = 0;
  int                       zero_seen = 0;

  // Intersect one ray with the mirrored disk; dot products kept exact at 2^-32
  function automatic disk_result_t disk_intersect(coord_t ox, coord_t oy, coord_t oz,
                                                  coord_t dx, coord_t dy, coord_t dz);
    longint          o [3];
    longint          d [3];
    longint          v [3];
    longint          num;
    longint          den;
    longint unsigned un;
    longint unsigned ud;
    longint unsigned tq;
    longint unsigned mv;
    longint unsigned sum;
    longint unsigned rr;
    logic [79:0]     quot;
    disk_result_t    res;
    res = '{hit: 1'b0, distance: '0};
    o[0] = ox;
    o[1] = oy;
    o[2] = oz;
    d[0] = dx;
    d[1] = dy;
    d[2] = dz;
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      den += longint'(disk_normal[i]) * d[i];
      num += (longint'(disk_center[i]) - o[i]) * longint'(disk_normal[i]);
    end
    // parallel ray, origin in the plane, or t behind the origin
    if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return res;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if ((un / ud) >= SAT_QUOTIENT) begin
      tq = T_SAT;
    end else begin
      quot = {un, 16'h0000} / {16'h0000, ud};
      tq = quot[63:0];
    end
    // hit point relative to the centre, each D*t term floored to Q16.16
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = o[i] - longint'(disk_center[i]) + ((d[i] * longint'(tq)) >>> 16);
      mv = (v[i] < 0) ? -v[i] : v[i];
      if (mv > disk_radius) return res;
      sum += mv * mv;
    end
    rr = 64'(disk_radius) * 64'(disk_radius);
    if (sum > rr) return res;
    res.hit = 1'b1;
    res.distance = tq[RAD_W-1:0];
    return res;
  endfunction

  // Mirror register writes, retire results, then queue predictions for new rays
  always @(posedge clk) begin : watch
    disk_result_t want;
    if (rst) begin
      disk_center[0] = '0;
      disk_center[1] = '0;
      disk_center[2] = '0;
      disk_radius = RAD_W'(32'h0001_0000);
      disk_normal[0] = '0;
      disk_normal[1] = '0;
      disk_normal[2] = NORM_W'(32'h0001_0000);
      predicted_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[4:2])
          REG_CENTER_X:    disk_center[0] = pwdata;
          REG_CENTER_Y:    disk_center[1] = pwdata;
          REG_CENTER_Z:    disk_center[2] = pwdata;
          REG_DISK_RADIUS: disk_radius = pwdata[RAD_W-1:0];
          REG_NORMAL_X:    disk_normal[0] = pwdata[NORM_W-1:0];
          REG_NORMAL_Y:    disk_normal[1] = pwdata[NORM_W-1:0];
          REG_NORMAL_Z:    disk_normal[2] = pwdata[NORM_W-1:0];
          default: ;  // no register here: drop the write
        endcase
      end

      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result with no ray in flight: hit %0b distance %h",
                     $realtime, hit, distance);
          mismatches++;
        end else begin
          want = predicted_q.pop_front();
          if (hit !== want.hit) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: result %0d hit: expected %0b, got %0b",
                       $realtime, results_seen, want.hit, hit);
            mismatches++;
          end
          if (distance !== want.distance) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: result %0d distance: expected %h, got %h",
                       $realtime, results_seen, want.distance, distance);
            mismatches++;
          end
          results_seen++;
        end
      end

      if (in_valid && !in_stall) begin
        want = disk_intersect(origin_x, origin_y, origin_z, dir_x, dir_y, dir_z);
        predicted_q.push_back(want);
        rays_seen++;
        if (want.hit) begin
          hits_seen++;
          if (want.distance == T_SAT) sat_seen++;
          if (want.distance == '0) zero_seen++;
        end
      end
    end

    error_count <= mismatches;
    results_pending <= predicted_q.size();
    rays_checked <= rays_seen;
    hit_count <= hits_seen;
    sat_hit_count <= sat_seen;
    zero_hit_count <= zero_seen;
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives rays into the ray/disk intersection unit, first a directed set on
// the reset disk, then random rays over a series of disk settings loaded
// through the register port. Rays arrive with random gaps and the output stalls at random; the
// checker beside the unit predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
  import rdi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime HALF_PERIOD    = 6ns;
  localparam int      RESET_CYCLES   = 12;
  localparam int      PHASES         = 9;
  localparam int      RAYS_PER_PHASE = 190;
  // longest quiet stretch: register loads plus heavy output stall, many times over
  localparam int      WATCHDOG_LIMIT = 2000;
  localparam int      TAIL_CYCLES    = 64;
  localparam int      ONE            = 32'h0001_0000;
  localparam int      MAX_COORD      = 32'h7FFF_FFFF;
  localparam int      MIN_COORD      = 32'h8000_0000;
  localparam longint  MAX_RADIUS     = 64'h7FFF_FFFF;
  localparam longint  REACH_CAP      = 64'd1 << 24;
  localparam logic [2:0] UNUSED_REG  = 3'd7;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;
  typedef enum logic [1:0] {DISK_AXIS, DISK_TILTED, DISK_EXTREME, DISK_POINT} disk_kind_t;

  typedef struct packed {
    coord_t ox, oy, oz;
    coord_t dx, dy, dz;
  } ray_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [4:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_stall;
  coord_t           origin_x = '0;
  coord_t           origin_y = '0;
  coord_t           origin_z = '0;
  coord_t           dir_x = '0;
  coord_t           dir_y = '0;
  coord_t           dir_z = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             hit;
  logic [RAD_W-1:0] distance;

  int error_count, results_pending, rays_checked;
  int hit_count, sat_hit_count, zero_hit_count;

  // disk currently loaded, as the stimulus sees it
  longint      cen [3];
  longint      nrm [3];
  longint      rad;
  int          burst_left = 0;
  int          idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  always #HALF_PERIOD clk = ~clk;

  ray_disk_intersect_unit dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall,
    .origin_x, .origin_y, .origin_z, .dir_x, .dir_y, .dir_z,
    .out_valid, .out_stall, .hit, .distance
  );

  disk_hit_checker hit_chk (
    .clk, .rst,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall,
    .origin_x, .origin_y, .origin_z, .dir_x, .dir_y, .dir_z,
    .out_valid, .out_stall, .hit, .distance,
    .error_count, .results_pending, .rays_checked,
    .hit_count, .sat_hit_count, .zero_hit_count
  );

  // Stall the output in stretches: none, light or heavy
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      default:     out_stall <= ($urandom_range(0, 99) < 80);
    endcase
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic longint rand_span(longint lim);
    logic [63:0] u;
    u = {$urandom(), $urandom()};
    return longint'(u % (2 * lim + 1)) - lim;
  endfunction

  function automatic ray_t ray_of(coord_t ox, coord_t oy, coord_t oz,
                                  coord_t dx, coord_t dy, coord_t dz);
    return '{ox: ox, oy: oy, oz: oz, dx: dx, dy: dy, dz: dz};
  endfunction

  // Mostly rays aimed at the disk; some parallel, some noise, some starting just off the plane
  function automatic ray_t next_ray();
    longint tgt [3];
    longint org [3];
    longint dir [3];
    longint reach;
    longint h;
    longint s;
    int     pick;
    int     k;
    pick = $urandom_range(0, 99);
    reach = (rad < REACH_CAP) ? rad : REACH_CAP;
    for (int i = 0; i < 3; i++)
      tgt[i] = cen[i] + rand_span(($urandom_range(0, 1) != 0) ? reach : reach / 2);
    if (pick < 70) begin
      h = $urandom_range(reach + ONE, 8 * reach + ONE);
      if ($urandom_range(0, 1) != 0) h = -h;
      k = $urandom_range(0, 4);
      for (int i = 0; i < 3; i++) begin
        org[i] = cen[i] + rand_span(2 * reach) + ((nrm[i] * h) >>> 16);
        dir[i] = (tgt[i] - org[i]) >>> k;
      end
      // point some of them away from the disk
      if ($urandom_range(0, 7) == 0)
        for (int i = 0; i < 3; i++) dir[i] = -dir[i];
    end else if (pick < 80) begin
      s = $urandom_range(1, 1 << 13);
      for (int i = 0; i < 3; i++) org[i] = cen[i] + rand_span(4 * reach + ONE);
      if (nrm[0] == 0 && nrm[1] == 0) begin
        dir[0] = rand_span(64'd1 << 30);
        dir[1] = rand_span(64'd1 << 30);
      end else begin
        dir[0] = nrm[1] * s;
        dir[1] = -nrm[0] * s;
      end
      dir[2] = 0;
    end else if (pick < 92) begin
      for (int i = 0; i < 3; i++) begin
        org[i] = $urandom();
        dir[i] = $urandom();
      end
    end else begin
      // origin a hair off the plane, steep direction: tiny t
      h = $urandom_range(1, 4);
      k = $urandom_range(8, 14);
      for (int i = 0; i < 3; i++) begin
        org[i] = tgt[i] + ((nrm[i] * h) >>> 16);
        dir[i] = -(nrm[i] <<< k);
      end
    end
    return ray_of(coord_t'(org[0]), coord_t'(org[1]), coord_t'(org[2]),
                  coord_t'(dir[0]), coord_t'(dir[1]), coord_t'(dir[2]));
  endfunction

  task automatic choose_disk(input disk_kind_t kind);
    int axis;
    case (kind)
      DISK_AXIS: begin
        axis = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
          cen[i] = rand_span(64'd1 << 24);
          nrm[i] = 0;
        end
        nrm[axis] = ($urandom_range(0, 1) != 0) ? ONE : -ONE;
        rad = $urandom_range(1 << 12, 1 << 21);
      end
      DISK_TILTED: begin
        for (int i = 0; i < 3; i++) begin
          cen[i] = rand_span(64'd1 << 26);
          nrm[i] = rand_span(ONE);
        end
        rad = $urandom_range(1 << 10, 1 << 22);
      end
      DISK_EXTREME: begin
        for (int i = 0; i < 3; i++) begin
          cen[i] = ($urandom_range(0, 1) != 0) ? MAX_COORD : MIN_COORD;
          nrm[i] = ($urandom_range(0, 1) != 0) ? ONE : -ONE;
        end
        rad = MAX_RADIUS;
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          cen[i] = rand_span(64'd1 << 20);
          nrm[i] = rand_span(ONE);
        end
        rad = 0;
      end
    endcase
  endtask

  // Setup then access phase; psel stays up so writes run back to back
  task automatic cfg_write(input logic [2:0] index, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic program_disk();
    cfg_write(REG_CENTER_X, cen[0][31:0]);
    cfg_write(REG_CENTER_Y, cen[1][31:0]);
    cfg_write(REG_CENTER_Z, cen[2][31:0]);
    cfg_write(REG_DISK_RADIUS, rad[31:0]);
    cfg_write(REG_NORMAL_X, nrm[0][31:0]);
    cfg_write(REG_NORMAL_Y, nrm[1][31:0]);
    cfg_write(REG_NORMAL_Z, nrm[2][31:0]);
    // a write past the last register must change nothing
    cfg_write(UNUSED_REG, $urandom());
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one ray in bursts separated by random gaps; hold until taken
  task automatic send_ray(input ray_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    origin_x <= r.ox;
    origin_y <= r.oy;
    origin_z <= r.oz;
    dir_x <= r.dx;
    dir_y <= r.dy;
    dir_z <= r.dz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin : stimulus
    disk_kind_t plan [PHASES];
    plan = '{DISK_AXIS, DISK_TILTED, DISK_EXTREME, DISK_TILTED, DISK_AXIS,
             DISK_POINT, DISK_TILTED, DISK_AXIS, DISK_TILTED};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset disk: centre at zero, radius 1.0, normal along +z
    send_ray(ray_of(0, 0, 2 * ONE, 0, 0, -ONE));              // straight down
    send_ray(ray_of(0, 0, -2 * ONE, 0, 0, ONE));              // from below
    send_ray(ray_of(0, 0, ONE, ONE, 0, 0));                   // parallel
    send_ray(ray_of(0, 0, ONE, 0, 0, ONE));                   // pointing away
    send_ray(ray_of(ONE / 2, 0, 0, 0, 0, -ONE));              // origin in plane
    send_ray(ray_of(3 * ONE, 0, ONE, 0, 0, -ONE));            // far hit point
    send_ray(ray_of(ONE, 0, ONE, 0, 0, -ONE));                // exactly on the rim
    send_ray(ray_of(ONE + 1, 0, ONE, 0, 0, -ONE));            // just outside
    send_ray(ray_of(46340, 46340, ONE, 0, 0, -ONE));          // diagonal, inside
    send_ray(ray_of(46341, 46341, ONE, 0, 0, -ONE));          // diagonal, outside
    send_ray(ray_of(0, 0, 1, 0, 0, MIN_COORD));               // t below one lsb
    send_ray(ray_of(0, 0, ONE, 0, 0, -1));                    // saturated t
    send_ray(ray_of(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD));
    send_ray(ray_of(MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD));
    send_ray(ray_of(0, 0, MAX_COORD, 0, 0, MIN_COORD));
    send_ray(ray_of(0, 0, 0, 0, 0, 0));                       // null direction
    send_ray(ray_of(-ONE, ONE / 2, ONE, ONE, 0, -ONE));       // oblique hit
    drain();

    // Random rays over a series of disks, drained before each reload
    for (int p = 0; p < PHASES; p++) begin
      choose_disk(plan[p]);
      program_disk();
      repeat (RAYS_PER_PHASE) send_ray(next_ray());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d rays on the reset disk and %0d loaded disks (axis, tilted,",
             rays_checked, PHASES);
    $display("extreme, zero radius): %0d hits, %0d saturated, %0d at zero distance",
             hit_count, sat_hit_count, zero_hit_count);
    if (results_pending != 0)
      $display("%0d results never arrived", results_pending);
    if (error_count == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
